FILE: hdl/ffsa_pkg.sv
// Shared types and constants for the first-fit segment allocator.
// No dependencies; used by every module in hdl/ except ffsa_seg_mem.
package ffsa_pkg;

    localparam int MaxSegmentsDef = 64;
    localparam int SizeBitsDef    = 16;

    localparam logic [15:0] MemorySizeRst = 16'd1024;

    // register byte addresses on the APB port
    localparam logic [1:0] RegMemorySize = 2'd0;

    localparam logic       ModeAlloc = 1'b0;
    localparam logic       ModeFree  = 1'b1;

    localparam logic [1:0] StatusDone    = 2'd0;
    localparam logic [1:0] StatusNoFit   = 2'd1;
    localparam logic [1:0] StatusFull    = 2'd2;
    localparam logic [1:0] StatusNoOwner = 2'd3;

    typedef struct packed {
        logic        mode;
        logic [15:0] owner_id;
        logic [15:0] request_size;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] region_start;
    } resp_t;

endpackage

FILE: hdl/first_fit_segment_allocator.sv
// First-fit segment allocator. A request is taken when start is high and busy is low;
// its single result word appears on result with done high for exactly one cycle, and the
// receiver cannot stall it. A split shifts the entries above the hit up by one before
// its result word comes. A free returns its word when the owner's entry is found,
// but busy stays high while the table is compacted. The segment memory is read and
// written one entry per cycle as the table is walked.
// The first request after reset first seeds the table.
// Depends on ffsa_pkg, ffsa_cfg, ffsa_seg_mem and ffsa_ctrl.
module first_fit_segment_allocator #(
    parameter int MAX_SEGMENTS = ffsa_pkg::MaxSegmentsDef,
    parameter int SIZE_BITS    = ffsa_pkg::SizeBitsDef
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  ffsa_pkg::req_t  req,
    output logic            done,
    output ffsa_pkg::resp_t result,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [1:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    localparam int IdxW = $clog2(MAX_SEGMENTS);
    localparam int SegW = 2 * SIZE_BITS + 17;

    logic [15:0]     memory_size;
    logic            mem_wr_en;
    logic [IdxW-1:0] mem_wr_addr;
    logic [SegW-1:0] mem_wr_data;
    logic            mem_rd_en;
    logic [IdxW-1:0] mem_rd_addr;
    logic [SegW-1:0] mem_rd_data;

    ffsa_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .memory_size (memory_size)
    );

    ffsa_seg_mem #(
        .DEPTH  (MAX_SEGMENTS),
        .DATA_W (SegW)
    ) u_seg_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    ffsa_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .SIZE_BITS    (SIZE_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .done        (done),
        .result      (result),
        .memory_size (memory_size),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

endmodule

FILE: hdl/ffsa_seg_mem.sv
// Segment table storage: one write port, one read port, registered read data.
// Uses no package items.
module ffsa_seg_mem #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 49
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/ffsa_cfg.sv
// APB register block holding memory_size.
// Depends on ffsa_pkg.
module ffsa_cfg (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] memory_size
);

    logic [15:0] memory_size_reg;
    logic [15:0] memory_size_next;

    always_comb
    begin
        memory_size_next = memory_size_reg;
        if (psel && penable && pwrite && paddr == ffsa_pkg::RegMemorySize)
        begin
            memory_size_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            memory_size_reg <= ffsa_pkg::MemorySizeRst;
        end
        else
        begin
            memory_size_reg <= memory_size_next;
        end
    end

    assign prdata      = (paddr == ffsa_pkg::RegMemorySize) ? {16'd0, memory_size_reg} : 32'd0;
    assign pready      = 1'b1;
    assign memory_size = memory_size_reg;

endmodule

FILE: hdl/ffsa_ctrl.sv
// Request sequencer: seeds, scans, shifts for a split and compacts after a free.
// Depends on ffsa_pkg; drives the ports of ffsa_seg_mem.
module ffsa_ctrl #(
    parameter int MAX_SEGMENTS = ffsa_pkg::MaxSegmentsDef,
    parameter int SIZE_BITS    = ffsa_pkg::SizeBitsDef,
    localparam int IdxW = $clog2(MAX_SEGMENTS),
    localparam int SegW = 2 * SIZE_BITS + 17
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ffsa_pkg::req_t      req,
    output logic                done,
    output ffsa_pkg::resp_t     result,
    input  logic [15:0]         memory_size,
    output logic                mem_wr_en,
    output logic [IdxW-1:0]     mem_wr_addr,
    output logic [SegW-1:0]     mem_wr_data,
    output logic                mem_rd_en,
    output logic [IdxW-1:0]     mem_rd_addr,
    input  logic [SegW-1:0]     mem_rd_data
);

    localparam int CntW = $clog2(MAX_SEGMENTS + 1);

    typedef struct packed {
        logic [SIZE_BITS-1:0] seg_start;
        logic [SIZE_BITS-1:0] seg_len;
        logic                 is_free;
        logic [15:0]          owner;
    } seg_t;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_SEED     = 7'b0000010,
        ST_SCAN     = 7'b0000100,
        ST_SHIFT    = 7'b0001000,
        ST_SPLIT_HI = 7'b0010000,
        ST_SPLIT_LO = 7'b0100000,
        ST_MERGE    = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [CntW-1:0]     count_reg, count_next;
    logic                mode_reg, mode_next;
    logic [15:0]         owner_reg, owner_next;
    logic [SIZE_BITS-1:0] size_reg, size_next;
    logic [CntW-1:0]     rptr_reg, rptr_next;
    logic                chk_vld_reg, chk_vld_next;
    logic [IdxW-1:0]     chk_idx_reg, chk_idx_next;
    logic [IdxW-1:0]     hit_idx_reg, hit_idx_next;
    seg_t                hit_seg_reg, hit_seg_next;
    seg_t                acc_reg, acc_next;
    logic                acc_vld_reg, acc_vld_next;
    logic [CntW-1:0]     wptr_reg, wptr_next;
    logic                done_reg, done_next;
    ffsa_pkg::resp_t     result_reg, result_next;

    seg_t                rd_seg;
    seg_t                wr_seg;
    seg_t                cur_seg;
    logic [31:0]         req_size_w;
    logic [31:0]         mem_size_w;
    logic [31:0]         start_w;
    logic                hit;

    assign rd_seg     = seg_t'(mem_rd_data);
    assign req_size_w = 32'(req.request_size);
    assign mem_size_w = 32'(memory_size);
    assign start_w    = 32'(rd_seg.seg_start);

    // entry under test, with the release applied during compaction
    always_comb
    begin
        cur_seg = rd_seg;
        if (state_reg == ST_MERGE && chk_idx_reg == hit_idx_reg)
        begin
            cur_seg.is_free = 1'b1;
            cur_seg.owner   = 16'd0;
        end
    end

    assign hit = (mode_reg == ffsa_pkg::ModeAlloc)
               ? (rd_seg.is_free && rd_seg.seg_len >= size_reg)
               : (!rd_seg.is_free && rd_seg.owner == owner_reg);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        mode_next    = mode_reg;
        owner_next   = owner_reg;
        size_next    = size_reg;
        rptr_next    = rptr_reg;
        chk_vld_next = 1'b0;
        chk_idx_next = chk_idx_reg;
        hit_idx_next = hit_idx_reg;
        hit_seg_next = hit_seg_reg;
        acc_next     = acc_reg;
        acc_vld_next = acc_vld_reg;
        wptr_next    = wptr_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = '0;
        wr_seg       = cur_seg;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = rptr_reg[IdxW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    mode_next  = req.mode;
                    owner_next = req.owner_id;
                    size_next  = req_size_w[SIZE_BITS-1:0];
                    rptr_next  = '0;
                    state_next = (count_reg == '0) ? ST_SEED : ST_SCAN;
                end
            end
            ST_SEED:
            begin
                mem_wr_en         = 1'b1;
                mem_wr_addr       = '0;
                wr_seg.seg_start  = '0;
                wr_seg.seg_len    = mem_size_w[SIZE_BITS-1:0];
                wr_seg.is_free    = 1'b1;
                wr_seg.owner      = 16'd0;
                count_next        = CntW'(1);
                state_next        = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (mode_reg == ffsa_pkg::ModeAlloc && size_reg == '0)
                begin
                    done_next   = 1'b1;
                    result_next = '{status: ffsa_pkg::StatusNoFit, region_start: 16'd0};
                    state_next  = ST_IDLE;
                end
                else if (chk_vld_reg && hit)
                begin
                    hit_idx_next = chk_idx_reg;
                    hit_seg_next = rd_seg;
                    if (mode_reg == ffsa_pkg::ModeFree)
                    begin
                        done_next    = 1'b1;
                        result_next  = '{status: ffsa_pkg::StatusDone,
                                         region_start: start_w[15:0]};
                        rptr_next    = '0;
                        acc_vld_next = 1'b0;
                        wptr_next    = '0;
                        state_next   = ST_MERGE;
                    end
                    else if (rd_seg.seg_len == size_reg)
                    begin
                        mem_wr_en      = 1'b1;
                        mem_wr_addr    = chk_idx_reg;
                        wr_seg         = rd_seg;
                        wr_seg.is_free = 1'b0;
                        wr_seg.owner   = owner_reg;
                        done_next      = 1'b1;
                        result_next    = '{status: ffsa_pkg::StatusDone,
                                           region_start: start_w[15:0]};
                        state_next     = ST_IDLE;
                    end
                    else if (count_reg == CntW'(MAX_SEGMENTS))
                    begin
                        done_next   = 1'b1;
                        result_next = '{status: ffsa_pkg::StatusFull, region_start: 16'd0};
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        rptr_next  = count_reg - CntW'(1);
                        state_next = ST_SHIFT;
                    end
                end
                else if (rptr_reg < count_reg)
                begin
                    mem_rd_en    = 1'b1;
                    chk_vld_next = 1'b1;
                    chk_idx_next = rptr_reg[IdxW-1:0];
                    rptr_next    = rptr_reg + CntW'(1);
                end
                else if (!chk_vld_reg)
                begin
                    done_next   = 1'b1;
                    result_next.region_start = 16'd0;
                    result_next.status = (mode_reg == ffsa_pkg::ModeAlloc)
                                       ? ffsa_pkg::StatusNoFit : ffsa_pkg::StatusNoOwner;
                    state_next  = ST_IDLE;
                end
            end
            ST_SHIFT:
            begin
                // move entries above the split up by one, top first
                if (chk_vld_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = chk_idx_reg + IdxW'(1);
                    wr_seg      = rd_seg;
                end
                if (rptr_reg >= CntW'(hit_idx_reg) + CntW'(1))
                begin
                    mem_rd_en    = 1'b1;
                    chk_vld_next = 1'b1;
                    chk_idx_next = rptr_reg[IdxW-1:0];
                    rptr_next    = rptr_reg - CntW'(1);
                end
                else if (!chk_vld_reg)
                begin
                    state_next = ST_SPLIT_HI;
                end
            end
            ST_SPLIT_HI:
            begin
                mem_wr_en        = 1'b1;
                mem_wr_addr      = hit_idx_reg + IdxW'(1);
                wr_seg.seg_start = hit_seg_reg.seg_start + size_reg;
                wr_seg.seg_len   = hit_seg_reg.seg_len - size_reg;
                wr_seg.is_free   = 1'b1;
                wr_seg.owner     = 16'd0;
                state_next       = ST_SPLIT_LO;
            end
            ST_SPLIT_LO:
            begin
                mem_wr_en        = 1'b1;
                mem_wr_addr      = hit_idx_reg;
                wr_seg.seg_start = hit_seg_reg.seg_start;
                wr_seg.seg_len   = size_reg;
                wr_seg.is_free   = 1'b0;
                wr_seg.owner     = owner_reg;
                count_next       = count_reg + CntW'(1);
                done_next        = 1'b1;
                result_next      = '{status: ffsa_pkg::StatusDone,
                                     region_start: start_w[15:0]};
                result_next.region_start = 16'(32'(hit_seg_reg.seg_start));
                state_next       = ST_IDLE;
            end
            ST_MERGE:
            begin
                // compaction: fold runs of free entries into an accumulator
                if (chk_vld_reg)
                begin
                    if (!acc_vld_reg)
                    begin
                        acc_next     = cur_seg;
                        acc_vld_next = 1'b1;
                    end
                    else if (acc_reg.is_free && cur_seg.is_free)
                    begin
                        acc_next.seg_len = acc_reg.seg_len + cur_seg.seg_len;
                    end
                    else
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = wptr_reg[IdxW-1:0];
                        wr_seg      = acc_reg;
                        wptr_next   = wptr_reg + CntW'(1);
                        acc_next    = cur_seg;
                    end
                end
                if (rptr_reg < count_reg)
                begin
                    mem_rd_en    = 1'b1;
                    chk_vld_next = 1'b1;
                    chk_idx_next = rptr_reg[IdxW-1:0];
                    rptr_next    = rptr_reg + CntW'(1);
                end
                else if (!chk_vld_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = wptr_reg[IdxW-1:0];
                    wr_seg      = acc_reg;
                    count_next  = wptr_reg + CntW'(1);
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            chk_vld_reg <= 1'b0;
            acc_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            chk_vld_reg <= chk_vld_next;
            acc_vld_reg <= acc_vld_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        owner_reg   <= owner_next;
        size_reg    <= size_next;
        rptr_reg    <= rptr_next;
        chk_idx_reg <= chk_idx_next;
        hit_idx_reg <= hit_idx_next;
        hit_seg_reg <= hit_seg_next;
        acc_reg     <= acc_next;
        wptr_reg    <= wptr_next;
        result_reg  <= result_next;
    end

    assign mem_wr_data = SegW'(wr_seg);
    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign result      = result_reg;

endmodule
